@@ design/e2q_pkg.sv @@
// Package for the Euler-to-quaternion block: sample types, lane indexes,
// the CORDIC arctangent table and elaboration-time helpers for stage angles and gain.
// No dependencies.
package e2q_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIELD_BITS        = 16;
  localparam int ATAN_LEN          = 32;

  // Lane order inside the CORDIC row
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef logic signed [31:0] q30_t;
  typedef q30_t [2:0]         trio_t;
  typedef logic signed [15:0] q15_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
  };

  // Stage angle in units of 2^-(angle_bits+1) turn, rounded half up
  function automatic logic [63:0] stage_angle(int idx, int angle_bits);
    logic [63:0] t;
    int          sh;
    t  = {31'd0, ATAN_TURN[idx], 1'b0};
    sh = 32 - angle_bits;
    if (sh > 0) begin
      t = (t + (64'd1 << (sh - 1))) >> sh;
    end
    return t;
  endfunction

  // Gain correction in Q30 for the given number of stages
  function automatic logic [63:0] cordic_gain(int stages);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] q;
    logic [64:0] rem;
    p = 64'd1 << 30;
    for (int i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    // integer square root of p << 30
    n = p << 30;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > n) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    if (r == 0) r = 64'd1;
    // rounded 2^60 / r by shift and subtract
    num = (64'd1 << 60) + (r >> 1);
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, r}) begin
        rem  = rem - {1'b0, r};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

@@ design/e2q_cordic_cell.sv @@
// One CORDIC rotation cell: advances cosine, sine and residual angle of the
// roll, pitch and yaw lanes by one stage. Depends on e2q_pkg.
module e2q_cordic_cell #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           in_valid,
  input  e2q_pkg::trio_t                 in_x,
  input  e2q_pkg::trio_t                 in_y,
  input  logic [2:0][ANGLE_BITS+1:0]     in_z,
  output logic                           out_valid,
  output e2q_pkg::trio_t                 out_x,
  output e2q_pkg::trio_t                 out_y,
  output logic [2:0][ANGLE_BITS+1:0]     out_z
);
  import e2q_pkg::*;

  localparam int                    ZW    = ANGLE_BITS + 2;
  localparam logic [63:0]           ANG64 = stage_angle(STAGE, ANGLE_BITS);
  localparam logic signed [ZW-1:0]  ANG   = ANG64[ZW-1:0];

  trio_t                x_next;
  trio_t                y_next;
  logic [2:0][ZW-1:0]   z_next;

  // Rotate toward zero residual; zero residual counts as positive
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!in_z[l][ZW-1]) begin
        x_next[l] = $signed(in_x[l]) - ($signed(in_y[l]) >>> STAGE);
        y_next[l] = $signed(in_y[l]) + ($signed(in_x[l]) >>> STAGE);
        z_next[l] = $signed(in_z[l]) - ANG;
      end else begin
        x_next[l] = $signed(in_x[l]) + ($signed(in_y[l]) >>> STAGE);
        y_next[l] = $signed(in_y[l]) - ($signed(in_x[l]) >>> STAGE);
        z_next[l] = $signed(in_z[l]) + ANG;
      end
    end
  end

  // Hand the beat to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
    end
  end

endmodule

@@ design/e2q_product.sv @@
// Product back end: forms the four quaternion components from the half-angle
// cosines and sines as rounded triple products, then rounds to Q1.15 and saturates.
// Depends on e2q_pkg.
module e2q_product (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  e2q_pkg::trio_t  in_cos,
  input  e2q_pkg::trio_t  in_sin,
  output logic            out_valid,
  output e2q_pkg::q15_t   quat_x,
  output e2q_pkg::q15_t   quat_y,
  output e2q_pkg::q15_t   quat_z,
  output e2q_pkg::q15_t   quat_w
);
  import e2q_pkg::*;

  // Round a Q60 product back to Q30
  function automatic q30_t round_q30(logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  // Round a Q30 sum to Q15 and clamp
  function automatic q15_t sat_q15(logic signed [32:0] s);
    logic signed [33:0] t;
    t = ($signed({s[32], s}) + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (t < -34'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  logic                v1, v2, v3, v4;
  logic signed [63:0]  pr_sc, pr_cs, pr_cc, pr_ss;
  q30_t                cy1, sy1, cy2, sy2;
  q30_t                q_sc, q_cs, q_cc, q_ss;
  logic signed [63:0]  tp [8];
  logic signed [32:0]  sum_x, sum_y, sum_z, sum_w;

  // Valid bits along the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Roll-pitch pair products
  always_ff @(posedge clk) begin
    if (advance) begin
      pr_sc <= in_sin[LANE_ROLL] * in_cos[LANE_PITCH];
      pr_cs <= in_cos[LANE_ROLL] * in_sin[LANE_PITCH];
      pr_cc <= in_cos[LANE_ROLL] * in_cos[LANE_PITCH];
      pr_ss <= in_sin[LANE_ROLL] * in_sin[LANE_PITCH];
      cy1   <= in_cos[LANE_YAW];
      sy1   <= in_sin[LANE_YAW];
    end
  end

  // Round pair products
  always_ff @(posedge clk) begin
    if (advance) begin
      q_sc <= round_q30(pr_sc);
      q_cs <= round_q30(pr_cs);
      q_cc <= round_q30(pr_cc);
      q_ss <= round_q30(pr_ss);
      cy2  <= cy1;
      sy2  <= sy1;
    end
  end

  // Multiply by the yaw terms
  always_ff @(posedge clk) begin
    if (advance) begin
      tp[0] <= q_sc * cy2;
      tp[1] <= q_cs * sy2;
      tp[2] <= q_cs * cy2;
      tp[3] <= q_sc * sy2;
      tp[4] <= q_cc * sy2;
      tp[5] <= q_ss * cy2;
      tp[6] <= q_cc * cy2;
      tp[7] <= q_ss * sy2;
    end
  end

  // Round triple products and combine
  always_ff @(posedge clk) begin
    if (advance) begin
      sum_x <= 33'(round_q30(tp[0])) - 33'(round_q30(tp[1]));
      sum_y <= 33'(round_q30(tp[2])) + 33'(round_q30(tp[3]));
      sum_z <= 33'(round_q30(tp[4])) - 33'(round_q30(tp[5]));
      sum_w <= 33'(round_q30(tp[6])) + 33'(round_q30(tp[7]));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (advance) begin
      quat_x <= sat_q15(sum_x);
      quat_y <= sat_q15(sum_y);
      quat_z <= sat_q15(sum_z);
      quat_w <= sat_q15(sum_w);
    end
  end

endmodule

@@ design/euler_to_quaternion_core.sv @@
// Euler angles (Z-Y-X) to unit quaternion, fully pipelined.
// Input channel s_*: one beat carries roll, pitch and yaw as signed binary
// angles, the full 16-bit range spanning -pi..pi.
// Output channel m_*: one beat per input beat, quaternion x, y, z, w in Q1.15,
// saturated at +1 and -1, in input order.
// Pipeline: one register stage per CORDIC cell, then four back-end stages and
// one output register between accepted input and output valid.
// Throughput: one beat per cycle while the output is not stalled; the row of CORDIC
// cells and the product pipeline each start a new sample every cycle unless stalled.
// Stall: the whole pipeline advances when the output register is empty or
// being taken; while the receiver holds m_tready low with a result waiting,
// every stage holds and s_tready is low. Bubbles travel with the pipeline.
// Reset: rst clears all valid bits; no beat is in flight afterwards.
// ANGLE_BITS sets the CORDIC angle resolution, CORDIC_STAGES the number of cells.
// Depends on e2q_pkg, e2q_cordic_cell and e2q_product.
module euler_to_quaternion_core #(
  parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;

  localparam int           ZW     = ANGLE_BITS + 2;
  localparam logic [63:0]  GAIN64 = cordic_gain(CORDIC_STAGES);
  localparam q30_t         GAIN   = GAIN64[31:0];

  logic                advance;
  logic                vld [CORDIC_STAGES+1];
  trio_t               cx  [CORDIC_STAGES+1];
  trio_t               cy  [CORDIC_STAGES+1];
  logic [2:0][ZW-1:0]  cz  [CORDIC_STAGES+1];
  q15_t                qx, qy, qz, qw;

  // Advance when the output register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Seed the first cell
  assign vld[0] = s_tvalid;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cx[0][l] = GAIN;
      cy[0][l] = '0;
    end
  end

  // Rescale the half angle to CORDIC units
  for (genvar l = 0; l < 3; l++) begin : g_scale
    logic signed [FIELD_BITS-1:0] ang;
    assign ang = s_tdata[l*FIELD_BITS +: FIELD_BITS];
    if (ANGLE_BITS >= FIELD_BITS) begin : g_up
      assign cz[0][l] = ZW'(ang) <<< (ANGLE_BITS - FIELD_BITS);
    end else begin : g_down
      assign cz[0][l] = ZW'(ang >>> (FIELD_BITS - ANGLE_BITS));
    end
  end

  // Row of CORDIC cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    e2q_cordic_cell #(
      .STAGE      (i),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (vld[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .out_valid (vld[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1])
    );
  end

  e2q_product u_product (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (vld[CORDIC_STAGES]),
    .in_cos    (cx[CORDIC_STAGES]),
    .in_sin    (cy[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .quat_x    (qx),
    .quat_y    (qy),
    .quat_z    (qz),
    .quat_w    (qw)
  );

  assign m_tdata = {qw, qz, qy, qx};

  // Accepted beat lands in the first cell
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[1])
    else $error("accepted beat missing from first CORDIC cell");

  // A stalled output freezes the cell row
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vld[1]) && $stable(vld[CORDIC_STAGES]))
    else $error("cell row moved during output stall");

  // A waiting result blocks new input when not drained
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

@@ sim/euler_to_quaternion_core_tb.sv @@
// Self-checking testbench for euler_to_quaternion_core: drives roll/pitch/yaw beats,
// predicts each quaternion with a bit-exact CORDIC model and checks every output beat.
// Depends on e2q_pkg and the euler_to_quaternion_core RTL.
`timescale 1ns / 1ps

module euler_to_quaternion_core_tb;

  localparam int STAGES     = e2q_pkg::CORDIC_STAGES_DEF;  // predictor assumes ANGLE_BITS = 16
  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_LEN   = 300;
  localparam int N_RANDOM   = 2000;
  localparam int N_DIRECTED = 20;

  typedef e2q_pkg::q15_t q15_t;

  // Input beat, roll in the low bits
  typedef struct packed {
    q15_t yaw;
    q15_t pitch;
    q15_t roll;
  } angles_t;

  // Output beat, x in the low bits
  typedef struct packed {
    q15_t w;
    q15_t z;
    q15_t y;
    q15_t x;
  } quat_t;

  // Directed row: angles plus an optional hand-typed w
  typedef struct packed {
    q15_t roll;
    q15_t pitch;
    q15_t yaw;
    logic w_typed;
    q15_t w_want;
  } dir_row_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN16 [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41721, 32'd20860
  };

  // Zero angles: cos^3 rounds to +1 in Q15 and saturates
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7FFF},
    '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 16'h8000, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 16'h7FFF, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 16'h8000, 1'b0, 16'h0000},
    '{16'h0001, 16'h0001, 16'h0001, 1'b0, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{16'h4000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 16'hC000, 16'h0000, 1'b0, 16'h0000},
    '{16'h0000, 16'h0000, 16'h4000, 1'b0, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{16'h2000, 16'hE000, 16'h6000, 1'b0, 16'h0000},
    '{16'h0000, 16'h4000, 16'h4000, 1'b0, 16'h0000},
    '{16'h0000, 16'hC000, 16'h2000, 1'b0, 16'h0000}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // roll_angle, pitch_angle, yaw_angle
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // quat_x, quat_y, quat_z, quat_w

  // Side band that travels with the driven beat: hand-typed w, if any
  logic        w_typed;
  q15_t        w_typed_val;

  longint      cordic_k;
  quat_t       quat_due [$];
  int          errors;
  int          triples_sent;
  int          quats_checked;
  int          backpressure_cycles;
  int          quiet_cycles;
  bit          steady;
  bit          hold_req;

  euler_to_quaternion_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // CORDIC start value that cancels the stage gain, Q30
  function automatic longint gain_correction();
    longint unsigned p;
    longint unsigned s;
    p = 64'd1 << 30;
    for (int i = 0; i < STAGES; i++) p = p + (p >> (2 * i));
    s = int_sqrt(p << 30);
    if (s == 0) s = 1;
    return longint'(((64'd1 << 60) + s / 2) / s);
  endfunction

  // Cosine and sine of half the binary angle, Q30
  function automatic void half_sin_cos(input q15_t ang, output longint c, output longint s);
    longint          x;
    longint          y;
    longint          z;
    longint          nx;
    longint unsigned step;
    x = cordic_k;
    y = 0;
    z = longint'(ang);
    for (int i = 0; i < STAGES; i++) begin
      step = (({32'd0, ATAN_TURN16[i]} << 1) + (64'd1 << 15)) >> 16;
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(step);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(step);
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  // Q30 product, rounded half up
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // Q30 to Q15 with rounding and saturation
  function automatic q15_t q30_to_q15(longint v);
    longint r;
    r = (v + (longint'(1) << 14)) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return q15_t'(r);
  endfunction

  // Z-Y-X quaternion from three half-angle sine/cosine pairs
  function automatic quat_t euler_to_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t  q;
    half_sin_cos(a.roll, cr, sr);
    half_sin_cos(a.pitch, cp, sp);
    half_sin_cos(a.yaw, cy, sy);
    q.x = q30_to_q15(q30_mul(q30_mul(sr, cp), cy) - q30_mul(q30_mul(cr, sp), sy));
    q.y = q30_to_q15(q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy));
    q.z = q30_to_q15(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
    q.w = q30_to_q15(q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy));
    return q;
  endfunction

  // Random angle, weighted toward zero and toward +/-pi
  function automatic q15_t pick_angle();
    case ($urandom_range(7))
      0: return q15_t'(int'($urandom_range(127)) - 64);
      1: return q15_t'(32767 - int'($urandom_range(63)));
      2: return q15_t'(-32768 + int'($urandom_range(63)));
      default: return q15_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  // Offer one beat after a random gap; return once it is taken
  task automatic send_angles(angles_t a, logic typed, q15_t w);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 27) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= a;
    w_typed     <= typed;
    w_typed_val <= w;
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver: random back-pressure, one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // Monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (!rst) begin
      if (s_tvalid && !s_tready) backpressure_cycles++;
      if (s_tvalid && s_tready) begin
        want = euler_to_quat(angles_t'(s_tdata));
        if (w_typed) want.w = w_typed_val;
        quat_due.push_back(want);
        triples_sent++;
      end
      if (m_tvalid && m_tready) begin
        got = quat_t'(m_tdata);
        if (quat_due.size() == 0) begin
          report_mismatch($sformatf("quaternion beat with none pending: x=%0d y=%0d z=%0d w=%0d",
                                    got.x, got.y, got.z, got.w));
        end else begin
          want = quat_due.pop_front();
          quats_checked++;
          if (got.x !== want.x)
            report_mismatch($sformatf("beat %0d x: got %0d want %0d", quats_checked, got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("beat %0d y: got %0d want %0d", quats_checked, got.y, want.y));
          if (got.z !== want.z)
            report_mismatch($sformatf("beat %0d z: got %0d want %0d", quats_checked, got.z, want.z));
          if (got.w !== want.w)
            report_mismatch($sformatf("beat %0d w: got %0d want %0d", quats_checked, got.w, want.w));
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d quaternions pending",
                 quiet_cycles, quat_due.size());
        $display("[euler_to_quaternion_core] ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    angles_t a;
    rst                 = 1'b1;
    s_tvalid            = 1'b0;
    s_tdata             = '0;
    w_typed             = 1'b0;
    w_typed_val         = '0;
    steady              = 1'b0;
    hold_req            = 1'b0;
    errors              = 0;
    triples_sent        = 0;
    quats_checked       = 0;
    backpressure_cycles = 0;
    quiet_cycles        = 0;
    cordic_k            = gain_correction();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed rows: axis extremes, +/-pi, quarter turns, gimbal lock, bit patterns
    for (int r = 0; r < N_DIRECTED; r++) begin
      a.roll  = DIR_ROWS[r].roll;
      a.pitch = DIR_ROWS[r].pitch;
      a.yaw   = DIR_ROWS[r].yaw;
      send_angles(a, DIR_ROWS[r].w_typed, DIR_ROWS[r].w_want);
    end

    // Random angles; a stretch with no idling, then one long receiver hold
    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 500 && n < 900);
      if (n == 1200) hold_req = 1'b1;
      a.roll  = pick_angle();
      a.pitch = pick_angle();
      a.yaw   = pick_angle();
      send_angles(a, 1'b0, '0);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    w_typed  <= 1'b0;

    // Drain, then let the pipeline settle
    while (quat_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d angle triples (directed extremes and random), %0d quaternions compared,",
             triples_sent, quats_checked);
    $display("%0d cycles with input held off by back-pressure, %0d mismatches",
             backpressure_cycles, errors);
    if (errors == 0) begin
      $display("[euler_to_quaternion_core] OK");
    end else begin
      $display("[euler_to_quaternion_core] ERROR");
    end
    $finish;
  end

endmodule
